// ===== rtl/core/pdpq_pkg.sv =====
`timescale 1ns / 1ps

package pdpq_pkg;

  // Queue geometry. The ring has room for at least one entry beyond the depth, because an
  // enqueue into a full queue briefly holds one extra entry before a drop.
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int RING_DEPTH  = 2 ** PTR_W;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 2);
  localparam int MIN_LIMIT   = 2;
  localparam int MAX_DROPS   = QUEUE_DEPTH - 2;

  localparam int LIMIT_W    = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_FINISH  = 2'd1,
    ACT_MUTE    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PRIO_NORMAL    = 2'd0,
    PRIO_ELEVATED  = 2'd1,
    PRIO_CRITICAL  = 2'd2,
    PRIO_IMMEDIATE = 2'd3
  } prio_e;

  typedef enum logic [1:0] {
    EV_DROP  = 2'd0,
    EV_START = 2'd1,
    EV_SIZE  = 2'd2
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT    = 1'd0,
    CFG_ATTACHED = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] phrase_tag;
    logic        phrase_empty;
    logic [1:0]  priority_class;
    logic        mute_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] event_tag;
    logic [4:0]  queue_size;
    logic        last_event;
  } out_beat_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          prio;
  } slot_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    slot_t            wr_data;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

endpackage

// ===== rtl/core/pdpq_store.sv =====
`timescale 1ns / 1ps

module pdpq_store import pdpq_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output slot_t    rd_data_o
);

  slot_t mem_q [RING_DEPTH];
  slot_t rd_data_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/pdpq_out.sv =====
`timescale 1ns / 1ps

module pdpq_out import pdpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      ev_valid_i,
  output logic      ev_ready_o,
  input  out_beat_t ev_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  logic      valid_q;
  out_beat_t beat_q;

  assign ev_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ev_ready_o) begin
      valid_q <= ev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_valid_i && ev_ready_o) begin
      beat_q <= ev_beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

// ===== rtl/core/pdpq_ctrl.sv =====
`timescale 1ns / 1ps

module pdpq_ctrl import pdpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  input  cfg_req_t  cfg_i,
  output mem_req_t  mem_o,
  input  slot_t     rd_data_i,
  output logic      ev_valid_o,
  input  logic      ev_ready_i,
  output out_beat_t ev_beat_o
);

  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_MDROP  = 19'h00002,
    ST_INSERT = 19'h00004,
    ST_CHECK  = 19'h00008,
    ST_SRD    = 19'h00010,
    ST_SCHK   = 19'h00020,
    ST_TRD    = 19'h00040,
    ST_TTAG   = 19'h00080,
    ST_MRD    = 19'h00100,
    ST_MWR    = 19'h00200,
    ST_DROP   = 19'h00400,
    ST_SIZE   = 19'h00800,
    ST_PRD    = 19'h01000,
    ST_PTAG   = 19'h02000,
    ST_PSIZE  = 19'h04000,
    ST_PSTART = 19'h08000,
    ST_FRD    = 19'h10000,
    ST_FEMIT  = 19'h20000,
    ST_FSIZE  = 19'h40000
  } state_e;

  state_e              state_q, state_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    drops_q, drops_d;
  logic                busy_q, busy_d;
  logic                muted_q, muted_d;
  logic [LIMIT_W-1:0]  lim_q;
  logic                attached_q;
  logic [TAG_BITS-1:0] vtag_q, vtag_d;
  in_beat_t            in_q;

  logic [CNT_W-1:0]    lim_eff;
  logic [CNT_W:0]      idx_p1;
  logic [CNT_W:0]      idx_p2;
  logic                high_prio;
  logic                in_acc;
  logic                pump_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign idx_p1     = {1'b0, idx_q} + (CNT_W + 1)'(1);
  assign idx_p2     = {1'b0, idx_q} + (CNT_W + 1)'(2);
  assign high_prio  = prio_e'(in_q.priority_class) inside {PRIO_CRITICAL, PRIO_IMMEDIATE};
  assign pump_ok    = !busy_q && attached_q;

  // The limit register is clamped to the range the queue can hold.
  always_comb begin
    if (32'(lim_q) < MIN_LIMIT) begin
      lim_eff = CNT_W'(MIN_LIMIT);
    end else if (32'(lim_q) > QUEUE_DEPTH) begin
      lim_eff = CNT_W'(QUEUE_DEPTH);
    end else begin
      lim_eff = CNT_W'(lim_q);
    end
  end

  // Memory requests. Logical position p lives at ring address head + p.
  always_comb begin
    mem_o = '0;
    case (state_q)
      ST_INSERT: begin
        mem_o.wr_en        = 1'b1;
        mem_o.wr_addr      = high_prio ? head_q - PTR_W'(1) : head_q + PTR_W'(count_q);
        mem_o.wr_data.tag  = in_q.phrase_tag[TAG_BITS-1:0];
        mem_o.wr_data.prio = in_q.priority_class;
      end
      ST_SRD, ST_TRD, ST_FRD: begin
        mem_o.rd_en   = 1'b1;
        mem_o.rd_addr = head_q + PTR_W'(idx_q);
      end
      ST_PRD: begin
        mem_o.rd_en   = 1'b1;
        mem_o.rd_addr = head_q;
      end
      ST_MRD: begin
        mem_o.rd_en   = 1'b1;
        mem_o.rd_addr = head_q + PTR_W'(idx_p1);
      end
      ST_MWR: begin
        mem_o.wr_en   = 1'b1;
        mem_o.wr_addr = head_q + PTR_W'(idx_q);
        mem_o.wr_data = rd_data_i;
      end
      default: begin
        mem_o = '0;
      end
    endcase
  end

  // Result beats toward the output register.
  always_comb begin
    ev_valid_o = 1'b1;
    ev_beat_o  = '0;
    case (state_q)
      ST_MDROP: begin
        ev_beat_o.event_kind = EV_DROP;
        ev_beat_o.event_tag  = 16'(in_q.phrase_tag[TAG_BITS-1:0]);
        ev_beat_o.queue_size = 5'(count_q);
        ev_beat_o.last_event = 1'b1;
      end
      ST_DROP: begin
        ev_beat_o.event_kind = EV_DROP;
        ev_beat_o.event_tag  = 16'(vtag_q);
        ev_beat_o.queue_size = 5'(count_q);
      end
      ST_SIZE: begin
        ev_beat_o.event_kind = EV_SIZE;
        ev_beat_o.queue_size = 5'(count_q);
        ev_beat_o.last_event = !pump_ok;
      end
      ST_PSIZE: begin
        ev_beat_o.event_kind = EV_SIZE;
        ev_beat_o.queue_size = 5'(count_q);
      end
      ST_PSTART: begin
        ev_beat_o.event_kind = EV_START;
        ev_beat_o.event_tag  = 16'(vtag_q);
        ev_beat_o.queue_size = 5'(count_q);
        ev_beat_o.last_event = 1'b1;
      end
      ST_FEMIT: begin
        ev_beat_o.event_kind = EV_DROP;
        ev_beat_o.event_tag  = 16'(rd_data_i.tag);
        ev_beat_o.queue_size = 5'(count_q - CNT_W'(1) - idx_q);
      end
      ST_FSIZE: begin
        ev_beat_o.event_kind = EV_SIZE;
        ev_beat_o.last_event = 1'b1;
      end
      default: begin
        ev_valid_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    drops_d = drops_q;
    busy_d  = busy_q;
    muted_d = muted_q;
    vtag_d  = vtag_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (action_e'(in_beat_i.action))
            ACT_ENQUEUE: begin
              if (!in_beat_i.phrase_empty) begin
                state_d = muted_q ? ST_MDROP : ST_INSERT;
              end
            end
            ACT_FINISH: begin
              busy_d = 1'b0;
              if (attached_q && (count_q != '0)) begin
                state_d = ST_PRD;
              end
            end
            ACT_MUTE: begin
              muted_d = in_beat_i.mute_value;
              idx_d   = '0;
              if (in_beat_i.mute_value && (count_q != '0)) begin
                state_d = ST_FRD;
              end
            end
            ACT_CLEAR: begin
              idx_d = '0;
              if (count_q != '0) begin
                state_d = ST_FRD;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MDROP: begin
        if (ev_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_INSERT: begin
        if (high_prio) begin
          head_d = head_q - PTR_W'(1);
        end
        count_d = count_q + CNT_W'(1);
        drops_d = '0;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if ((count_q > lim_eff) && (drops_q < CNT_W'(MAX_DROPS))) begin
          idx_d   = '0;
          state_d = ST_SRD;
        end else begin
          state_d = ST_SIZE;
        end
      end
      ST_SRD: begin
        state_d = ST_SCHK;
      end
      ST_SCHK: begin
        // The oldest normal phrase is the victim; with none, the head.
        if (prio_e'(rd_data_i.prio) == PRIO_NORMAL) begin
          state_d = ST_TRD;
        end else if (idx_p1 == {1'b0, count_q}) begin
          idx_d   = '0;
          state_d = ST_TRD;
        end else begin
          idx_d   = CNT_W'(idx_p1);
          state_d = ST_SRD;
        end
      end
      ST_TRD: begin
        state_d = ST_TTAG;
      end
      ST_TTAG: begin
        vtag_d = rd_data_i.tag;
        if (idx_q == '0) begin
          head_d  = head_q + PTR_W'(1);
          count_d = count_q - CNT_W'(1);
          state_d = ST_DROP;
        end else if (idx_p1 < {1'b0, count_q}) begin
          state_d = ST_MRD;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DROP;
        end
      end
      ST_MRD: begin
        state_d = ST_MWR;
      end
      ST_MWR: begin
        if (idx_p2 < {1'b0, count_q}) begin
          idx_d   = CNT_W'(idx_p1);
          state_d = ST_MRD;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DROP;
        end
      end
      ST_DROP: begin
        if (ev_ready_i) begin
          drops_d = drops_q + CNT_W'(1);
          state_d = ST_CHECK;
        end
      end
      ST_SIZE: begin
        if (ev_ready_i) begin
          state_d = pump_ok ? ST_PRD : ST_IDLE;
        end
      end
      ST_PRD: begin
        state_d = ST_PTAG;
      end
      ST_PTAG: begin
        vtag_d  = rd_data_i.tag;
        head_d  = head_q + PTR_W'(1);
        count_d = count_q - CNT_W'(1);
        busy_d  = 1'b1;
        state_d = ST_PSIZE;
      end
      ST_PSIZE: begin
        if (ev_ready_i) begin
          state_d = ST_PSTART;
        end
      end
      ST_PSTART: begin
        if (ev_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_FRD: begin
        state_d = ST_FEMIT;
      end
      ST_FEMIT: begin
        if (ev_ready_i) begin
          if (idx_p1 == {1'b0, count_q}) begin
            count_d = '0;
            state_d = ST_FSIZE;
          end else begin
            idx_d   = CNT_W'(idx_p1);
            state_d = ST_FRD;
          end
        end
      end
      ST_FSIZE: begin
        if (ev_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      drops_q    <= '0;
      busy_q     <= 1'b0;
      muted_q    <= 1'b0;
      lim_q      <= LIMIT_RESET;
      attached_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      drops_q <= drops_d;
      busy_q  <= busy_d;
      muted_q <= muted_d;
      if (cfg_i.valid) begin
        case (cfg_reg_e'(cfg_i.index))
          CFG_LIMIT: begin
            lim_q <= cfg_i.data[LIMIT_W-1:0];
          end
          CFG_ATTACHED: begin
            attached_q <= cfg_i.data[0];
          end
          default: begin
            lim_q <= lim_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vtag_q <= vtag_d;
    if (in_acc) begin
      in_q <= in_beat_i;
    end
  end

endmodule

// ===== rtl/core/priority_drop_phrase_queue.sv =====
// Input beats are taken one at a time: the next beat is accepted only when the sequencer is
// back in idle after handing off all result beats of the last one. A muted enqueue gives one
// drop beat, a flush one drop beat per entry, and an enqueue that overfills the queue drops
// victims, each found by a search through the read port and, from the middle, removed by
// shifting the younger entries down. An enqueue or a finish may also start the speaker.
// Reset: asynchronous, active low; empty queue, idle unmuted server, limit 16, no speaker.
`timescale 1ns / 1ps

module priority_drop_phrase_queue import pdpq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_beat_t             out_beat_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // The queue lives in a ring buffer inside pdpq_store. The sequencer keeps the
  // head pointer and fill count; a logical position p is the ring address
  // head + p. Taking the head advances the pointer, a critical or immediate
  // phrase is written just below the head, and a drop from the middle shifts
  // the younger entries down one by one through the read and write ports.

  cfg_req_t  cfg;
  mem_req_t  mem_req;
  slot_t     rd_data;
  logic      ev_valid;
  logic      ev_ready;
  out_beat_t ev_beat;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  pdpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .cfg_i      (cfg),
    .mem_o      (mem_req),
    .rd_data_i  (rd_data),
    .ev_valid_o (ev_valid),
    .ev_ready_i (ev_ready),
    .ev_beat_o  (ev_beat)
  );

  pdpq_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // The output register lets the last result beat wait while the next input
  // beat is already taken.
  pdpq_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (ev_valid),
    .ev_ready_o  (ev_ready),
    .ev_beat_i   (ev_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
